### hdl/smf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the slotted message queue
// Field widths, action and status codes, and the reset value of the limit.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int ACTION_W = 2;
  localparam int SIZE_W   = 7;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam action_t ACT_PUSH_BEGIN = 2'd0;
  localparam action_t ACT_PUSH_BYTE  = 2'd1;
  localparam action_t ACT_POP        = 2'd2;

  localparam status_t ST_PUSH_OK     = 2'd0;
  localparam status_t ST_PUSH_REJECT = 2'd1;
  localparam status_t ST_POP_EMPTY   = 2'd2;
  localparam status_t ST_POP_DATA    = 2'd3;

  localparam size_t LIMIT_RESET = 7'd64;

endpackage

### hdl/smf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module smf_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/slotted_message_fifo_top.sv
`timescale 1ns / 1ps
// A push item gives its single result in the cycle after the transfer.
// A pop reads the slot size and first byte from RAM, and its first result is
// registered from that read, then one byte per cycle while out_ready is high.
// One push item per cycle while out_ready is high; the input is not ready again
// until a pop of a stored message has sent its last result.
// Reset (synchronous, rst_n low) empties the queue, closes any open push and
// sets the limit to 64; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
// slotted_message_fifo_top: ring queue of fixed-stride message slots
// Messages are pushed byte by byte into a payload RAM and popped as a stream
// of bytes with a last marker; slot sizes live in a second small RAM.
// ----------------------------------------------------------------------------
module slotted_message_fifo_top #(
  parameter int SLOTS     = 8,
  parameter int MAX_BYTES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  smf_pkg::size_t   cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  smf_pkg::action_t in_action,
  input  smf_pkg::size_t   in_msg_size,
  input  smf_pkg::byte_t   in_data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output smf_pkg::status_t out_status,
  output smf_pkg::byte_t   out_byte,
  output smf_pkg::size_t   out_size,
  output logic             out_last
);

  import smf_pkg::*;

  localparam int DEPTH = SLOTS * MAX_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SLOTS);
  localparam logic [CW-1:0] SLOT_LAST = CW'(SLOTS - 1);
  localparam size_t MAX_SIZE = SIZE_W'(MAX_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_POP_LEN, S_POP_DATA} state_t;

  state_t        state_r, state_nxt;
  size_t         limit_r, limit_nxt;
  logic [CW-1:0] wr_slot_r, wr_slot_nxt, rd_slot_r, rd_slot_nxt;
  logic          wr_phase_r, wr_phase_nxt, rd_phase_r, rd_phase_nxt;
  logic          open_r, open_nxt;
  size_t         offset_r, offset_nxt, length_r, length_nxt;
  logic [AW-1:0] pop_base_r, pop_base_nxt;
  size_t         pop_idx_r, pop_idx_nxt, pop_len_r, pop_len_nxt;

  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  status_t       out_status_r, out_status_nxt;
  byte_t         out_byte_r, out_byte_nxt;
  size_t         out_size_r, out_size_nxt;

  logic          pay_we, pay_re, size_we, size_re;
  logic [AW-1:0] pay_waddr, pay_raddr, wr_base, rd_base;
  byte_t         pay_rdata;
  size_t         size_wdata, size_rdata, eff_limit, pop_len;
  logic          out_free, accept, empty, full;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign empty = (wr_slot_r == rd_slot_r) && (wr_phase_r == rd_phase_r);
  assign full  = (wr_slot_r == rd_slot_r) && (wr_phase_r != rd_phase_r);

  assign wr_base   = AW'(wr_slot_r) * AW'(MAX_BYTES);
  assign rd_base   = AW'(rd_slot_r) * AW'(MAX_BYTES);
  assign eff_limit = (limit_r > MAX_SIZE) ? MAX_SIZE : limit_r;
  assign pop_len   = (size_rdata > MAX_SIZE) ? MAX_SIZE : size_rdata;

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = cfg_wr_en ? cfg_wr_data : limit_r;
    wr_slot_nxt    = wr_slot_r;
    wr_phase_nxt   = wr_phase_r;
    rd_slot_nxt    = rd_slot_r;
    rd_phase_nxt   = rd_phase_r;
    open_nxt       = open_r;
    offset_nxt     = offset_r;
    length_nxt     = length_r;
    pop_base_nxt   = pop_base_r;
    pop_idx_nxt    = pop_idx_r;
    pop_len_nxt    = pop_len_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_size_nxt   = out_size_r;
    out_last_nxt   = out_last_r;
    pay_we         = 1'b0;
    pay_waddr      = wr_base + AW'(offset_r);
    pay_re         = 1'b0;
    pay_raddr      = pop_base_r + AW'(pop_idx_r + 7'd1);
    size_we        = 1'b0;
    size_wdata     = length_r;
    size_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_PUSH_BEGIN: begin
              // A new push_begin always abandons any push still open.
              open_nxt       = 1'b0;
              offset_nxt     = '0;
              out_valid_nxt  = 1'b1;
              out_byte_nxt   = '0;
              out_size_nxt   = '0;
              out_last_nxt   = 1'b1;
              if (eff_limit == '0 || in_msg_size > eff_limit || full) begin
                out_status_nxt = ST_PUSH_REJECT;
              end else begin
                out_status_nxt = ST_PUSH_OK;
                open_nxt       = 1'b1;
                length_nxt     = in_msg_size;
                if (in_msg_size == '0) begin
                  size_we    = 1'b1;
                  size_wdata = '0;
                  open_nxt   = 1'b0;
                  if (wr_slot_r == SLOT_LAST) begin
                    wr_slot_nxt  = '0;
                    wr_phase_nxt = !wr_phase_r;
                  end else begin
                    wr_slot_nxt = wr_slot_r + CW'(1);
                  end
                end
              end
            end
            ACT_PUSH_BYTE: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_size_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (!open_r || offset_r >= length_r) begin
                open_nxt       = 1'b0;
                out_status_nxt = ST_PUSH_REJECT;
              end else begin
                out_status_nxt = ST_PUSH_OK;
                pay_we         = 1'b1;
                offset_nxt     = offset_r + 7'd1;
                if (offset_r + 7'd1 == length_r) begin
                  size_we    = 1'b1;
                  open_nxt   = 1'b0;
                  offset_nxt = '0;
                  if (wr_slot_r == SLOT_LAST) begin
                    wr_slot_nxt  = '0;
                    wr_phase_nxt = !wr_phase_r;
                  end else begin
                    wr_slot_nxt = wr_slot_r + CW'(1);
                  end
                end
              end
            end
            ACT_POP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_POP_EMPTY;
                out_byte_nxt   = '0;
                out_size_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                // Fetch the size and the first byte together.
                size_re      = 1'b1;
                pay_re       = 1'b1;
                pay_raddr    = rd_base;
                pop_base_nxt = rd_base;
                state_nxt    = S_POP_LEN;
                if (rd_slot_r == SLOT_LAST) begin
                  rd_slot_nxt  = '0;
                  rd_phase_nxt = !rd_phase_r;
                end else begin
                  rd_slot_nxt = rd_slot_r + CW'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP_LEN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_POP_DATA;
          pop_len_nxt    = pop_len;
          pop_idx_nxt    = '0;
          if (pop_len == '0) begin
            out_byte_nxt = '0;
            out_size_nxt = '0;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_byte_nxt = pay_rdata;
            out_size_nxt = pop_len;
            out_last_nxt = (pop_len == 7'd1);
            if (pop_len == 7'd1) begin
              state_nxt = S_IDLE;
            end else begin
              pay_re      = 1'b1;
              pay_raddr   = pop_base_r + AW'(1);
              pop_idx_nxt = 7'd1;
              state_nxt   = S_POP_DATA;
            end
          end
        end
      end
      S_POP_DATA: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_POP_DATA;
          out_byte_nxt   = pay_rdata;
          out_size_nxt   = pop_len_r;
          out_last_nxt   = (pop_idx_r + 7'd1 == pop_len_r);
          if (pop_idx_r + 7'd1 == pop_len_r) begin
            state_nxt = S_IDLE;
          end else begin
            pay_re      = 1'b1;
            pop_idx_nxt = pop_idx_r + 7'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      wr_slot_r   <= '0;
      wr_phase_r  <= 1'b0;
      rd_slot_r   <= '0;
      rd_phase_r  <= 1'b0;
      open_r      <= 1'b0;
      offset_r    <= '0;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      wr_slot_r   <= wr_slot_nxt;
      wr_phase_r  <= wr_phase_nxt;
      rd_slot_r   <= rd_slot_nxt;
      rd_phase_r  <= rd_phase_nxt;
      open_r      <= open_nxt;
      offset_r    <= offset_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pop_base_r   <= pop_base_nxt;
    pop_idx_r    <= pop_idx_nxt;
    pop_len_r    <= pop_len_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_size_r   <= out_size_nxt;
    out_last_r   <= out_last_nxt;
  end

  smf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (pay_we),
    .wr_addr (pay_waddr),
    .wr_data (in_data_byte),
    .rd_en   (pay_re),
    .rd_addr (pay_raddr),
    .rd_data (pay_rdata)
  );

  smf_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (SLOTS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (size_we),
    .wr_addr (wr_slot_r),
    .wr_data (size_wdata),
    .rd_en   (size_re),
    .rd_addr (rd_slot_r),
    .rd_data (size_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_byte   = out_byte_r;
  assign out_size   = out_size_r;
  assign out_last   = out_last_r;

endmodule

### tb/sv/slotted_message_fifo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slotted_message_fifo_top_tb: self-checking bench for the slotted message queue
// A scoreboard mirrors the ring of message slots and predicts every result of
// each accepted input transfer. Directed items cover rejects, abandoned pushes,
// a full queue and limit changes, then random traffic runs under several
// idling patterns and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module slotted_message_fifo_top_tb;

  import smf_pkg::*;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_BYTES = 64;

  class msg_queue_scoreboard;

    typedef struct {
      status_t status;
      byte_t   data;
      size_t   size;
      logic    last;
    } reply_t;

    byte_t      payload [SLOT_COUNT*SLOT_BYTES];
    size_t      lengths [SLOT_COUNT];
    logic [3:0] wr_count;
    logic [3:0] rd_count;
    bit         push_open;
    int         push_offset;
    int         push_length;
    int         limit;
    reply_t     awaited [$];
    int         failures;

    function new();
      wr_count    = '0;
      rd_count    = '0;
      push_open   = 1'b0;
      push_offset = 0;
      push_length = 0;
      limit       = int'(LIMIT_RESET);
      failures    = 0;
    endfunction

    function void set_limit(size_t value);
      limit = int'(value);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void queue_reply(status_t st, byte_t data, size_t size, logic last);
      reply_t r;
      r.status = st;
      r.data   = data;
      r.size   = size;
      r.last   = last;
      awaited.push_back(r);
    endfunction

    function void commit_message();
      lengths[wr_count % SLOT_COUNT] = size_t'(push_length);
      wr_count    = wr_count + 4'd1;
      push_open   = 1'b0;
      push_offset = 0;
    endfunction

    function void note_accepted_item(action_t act, size_t msg_size, byte_t data);
      int         eff_limit;
      int         slot;
      int         len;
      logic [3:0] used;
      case (act)
        ACT_PUSH_BEGIN: begin
          eff_limit   = (limit > SLOT_BYTES) ? SLOT_BYTES : limit;
          used        = wr_count - rd_count;
          // A new push always abandons whatever push was still open.
          push_open   = 1'b0;
          push_offset = 0;
          if (eff_limit == 0 || int'(msg_size) > eff_limit || used >= SLOT_COUNT) begin
            queue_reply(ST_PUSH_REJECT, '0, '0, 1'b1);
          end else begin
            push_open   = 1'b1;
            push_length = int'(msg_size);
            if (msg_size == 0) commit_message();
            queue_reply(ST_PUSH_OK, '0, '0, 1'b1);
          end
        end
        ACT_PUSH_BYTE: begin
          if (!push_open || push_offset >= push_length) begin
            push_open = 1'b0;
            queue_reply(ST_PUSH_REJECT, '0, '0, 1'b1);
          end else begin
            slot = wr_count % SLOT_COUNT;
            payload[slot*SLOT_BYTES + push_offset] = data;
            push_offset++;
            if (push_offset == push_length) commit_message();
            queue_reply(ST_PUSH_OK, '0, '0, 1'b1);
          end
        end
        ACT_POP: begin
          if (rd_count == wr_count) begin
            queue_reply(ST_POP_EMPTY, '0, '0, 1'b1);
          end else begin
            slot     = rd_count % SLOT_COUNT;
            len      = int'(lengths[slot]);
            rd_count = rd_count + 4'd1;
            if (len == 0) begin
              queue_reply(ST_POP_DATA, '0, '0, 1'b1);
            end else begin
              for (int i = 0; i < len; i++)
                queue_reply(ST_POP_DATA, payload[slot*SLOT_BYTES + i], size_t'(len),
                            (i == len - 1));
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(status_t st, byte_t data, size_t size, logic last);
      reply_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with nothing awaited: status %0d byte %0d", st, data);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) begin
        $error("out_status: expected %0d, actual %0d", want.status, st);
        failures++;
      end
      if (data !== want.data) begin
        $error("out_byte: expected %0d, actual %0d", want.data, data);
        failures++;
      end
      if (size !== want.size) begin
        $error("out_size: expected %0d, actual %0d", want.size, size);
        failures++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0d, actual %0d", want.last, last);
        failures++;
      end
    endfunction

  endclass

  localparam action_t ACT_UNUSED     = 2'd3;
  localparam int      HOLD_CYCLES    = 300;
  localparam int      TAIL_CYCLES    = 8;
  localparam int      WATCHDOG_LIMIT = 3000;

  logic    clk;
  logic    rst_n        = 1'b0;
  logic    cfg_wr_en    = 1'b0;
  size_t   cfg_wr_data  = '0;
  logic    in_valid     = 1'b0;
  action_t in_action    = ACT_POP;
  size_t   in_msg_size  = '0;
  byte_t   in_data_byte = '0;
  logic    out_ready    = 1'b0;
  logic    in_ready;
  logic    out_valid;
  status_t out_status;
  byte_t   out_byte;
  size_t   out_size;
  logic    out_last;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_request       = 0;
  int items_sent         = 0;
  int quiet_cycles       = 0;

  msg_queue_scoreboard sb = new();

  slotted_message_fifo_top #(
    .SLOTS     (SLOT_COUNT),
    .MAX_BYTES (SLOT_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_msg_size  (in_msg_size),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_byte     (out_byte),
    .out_size     (out_size),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Both channels are sampled on the clock edge, before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_byte, out_size, out_last);
    if (rst_n && in_valid && in_ready)
      sb.note_accepted_item(in_action, in_msg_size, in_data_byte);
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("slotted_message_fifo_top_tb NOT OK");
    $finish;
  end

  // A hold request takes the receiver off line for the length of the hold.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_item(action_t act, size_t msg_size, byte_t data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_msg_size  <= msg_size;
    in_data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Waits until every predicted result has arrived, plus the pipeline tail.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(size_t value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(value);
  endtask

  task automatic random_traffic(int count);
    int    target;
    int    r;
    int    n;
    int    k;
    size_t sz;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 45) begin
        // Well-formed message; sizes are mostly small to keep pops short.
        k = $urandom_range(99);
        if (k < 70)      sz = size_t'($urandom_range(8));
        else if (k < 92) sz = size_t'($urandom_range(SLOT_BYTES));
        else             sz = size_t'($urandom_range(127));
        send_item(ACT_PUSH_BEGIN, sz, byte_t'($urandom));
        for (int i = 0; i < sz; i++)
          send_item(ACT_PUSH_BYTE, size_t'($urandom), byte_t'($urandom));
      end else if (r < 80) begin
        send_item(ACT_POP, size_t'($urandom), byte_t'($urandom));
      end else begin
        case ($urandom_range(3))
          0: send_item(ACT_PUSH_BYTE, size_t'($urandom), byte_t'($urandom));
          1: begin
            n = 2 + $urandom_range(6);
            send_item(ACT_PUSH_BEGIN, size_t'(n), byte_t'($urandom));
            k = $urandom_range(n - 1);
            for (int i = 0; i < k; i++)
              send_item(ACT_PUSH_BYTE, size_t'($urandom), byte_t'($urandom));
          end
          2: send_item(ACT_UNUSED, size_t'($urandom), byte_t'($urandom));
          default: send_item(ACT_PUSH_BEGIN, size_t'($urandom_range(127)),
                             byte_t'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ACT_POP, 7'd0, 8'd0);
    send_item(ACT_PUSH_BYTE, 7'd127, 8'hFF);
    send_item(ACT_UNUSED, 7'd127, 8'hFF);
    send_item(ACT_PUSH_BEGIN, 7'd0, 8'd0);
    send_item(ACT_PUSH_BEGIN, 7'd2, 8'd0);
    send_item(ACT_PUSH_BYTE, 7'd0, 8'h00);
    send_item(ACT_PUSH_BYTE, 7'd0, 8'hFF);
    send_item(ACT_PUSH_BEGIN, 7'd127, 8'd0);
    // The three-byte push is dropped by the next begin; the pop in between
    // only sees committed messages.
    send_item(ACT_PUSH_BEGIN, 7'd3, 8'd0);
    send_item(ACT_PUSH_BYTE, 7'd0, 8'h5A);
    send_item(ACT_PUSH_BEGIN, 7'd1, 8'd0);
    send_item(ACT_POP, 7'd0, 8'd0);
    send_item(ACT_PUSH_BYTE, 7'd0, 8'hA5);
    for (int i = 0; i < 7; i++)
      send_item(ACT_PUSH_BEGIN, 7'd0, 8'd0);
    // A limit above the slot stride saturates, so 65 bytes is still too many.
    write_limit(7'd127);
    send_item(ACT_PUSH_BEGIN, 7'd65, 8'd0);
    send_item(ACT_POP, 7'd0, 8'd0);
    send_item(ACT_PUSH_BEGIN, 7'd4, 8'd0);
    send_item(ACT_PUSH_BYTE, 7'd0, 8'h11);
    // Lowering the limit mid-push must not shorten the open message.
    write_limit(7'd2);
    for (int i = 0; i < 3; i++)
      send_item(ACT_PUSH_BYTE, 7'd0, byte_t'($urandom));
    write_limit(7'd0);
    send_item(ACT_PUSH_BEGIN, 7'd0, 8'd0);

    write_limit(7'd64);
    random_traffic(60);

    write_limit(7'd127);
    sender_idle_pct = 62;
    random_traffic(60);

    write_limit(7'd9);
    sender_idle_pct    = 0;
    receiver_stall_pct = 62;
    random_traffic(60);

    write_limit(7'd1);
    sender_idle_pct    = 28;
    receiver_stall_pct = 28;
    random_traffic(45);

    write_limit(7'd64);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = HOLD_CYCLES;
    random_traffic(35);

    write_limit(7'd0);
    sender_idle_pct    = 28;
    receiver_stall_pct = 28;
    random_traffic(20);

    settle();
    if (sb.failures == 0)
      $display("slotted_message_fifo_top_tb OK");
    else
      $display("slotted_message_fifo_top_tb NOT OK");
    $finish;
  end

endmodule
